/* src/sgr_pkg.sv */
// Package with shared constants, codes and types for the switched graph reachability block.
`timescale 1ns / 1ps
package sgr_pkg;

    localparam int MAX_NODES = 16;
    localparam int MAX_EDGES = 32;

    localparam int NODE_IW  = $clog2(MAX_NODES);
    localparam int CNT_W    = $clog2(MAX_NODES + 1);
    localparam int FREE_W   = $clog2(MAX_EDGES + 1);
    localparam int ADDR_W   = 2 * NODE_IW;

    localparam int MODE_W   = 3;
    localparam int NODE_W   = 5;
    localparam int LABEL_W  = 6;
    localparam int STATUS_W = 2;
    localparam int NCNT_W   = 5;
    localparam int BUDGET_W = 6;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [MODE_W-1:0] MODE_CONNECT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DISCONNECT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_LABEL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR_VIS  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

    localparam logic [PADDR_W-3:0] REG_NODE_COUNT  = 1'd0;
    localparam logic [PADDR_W-3:0] REG_EDGE_BUDGET = 1'd1;

    typedef struct packed {
        logic [CNT_W-1:0]  eff_nodes;
        logic [FREE_W-1:0] eff_budget;
    } cfg_t;

endpackage

/* src/sgr_cfg.sv */
// Configuration registers with APB access and saturation of the node count and edge budget.
`timescale 1ns / 1ps
module sgr_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sgr_pkg::PADDR_W-1:0]   paddr,
    input  logic [sgr_pkg::PDATA_W-1:0]   pwdata,
    output logic [sgr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output sgr_pkg::cfg_t                 cfg
);

    logic [sgr_pkg::NCNT_W-1:0]   node_count_reg;
    logic [sgr_pkg::BUDGET_W-1:0] edge_budget_reg;
    logic [sgr_pkg::PADDR_W-3:0]  idx;
    logic                         wr_en;

    assign idx    = paddr[sgr_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg  <= sgr_pkg::NCNT_W'(16);
            edge_budget_reg <= sgr_pkg::BUDGET_W'(32);
        end else if (wr_en) begin
            unique case (idx)
                sgr_pkg::REG_NODE_COUNT:  node_count_reg  <= pwdata[sgr_pkg::NCNT_W-1:0];
                sgr_pkg::REG_EDGE_BUDGET: edge_budget_reg <= pwdata[sgr_pkg::BUDGET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            sgr_pkg::REG_NODE_COUNT:
                prdata = sgr_pkg::PDATA_W'(node_count_reg);
            sgr_pkg::REG_EDGE_BUDGET:
                prdata = sgr_pkg::PDATA_W'(edge_budget_reg);
            default:
                prdata = '0;
        endcase
    end

    always_comb begin
        if (node_count_reg == '0)
            cfg.eff_nodes = sgr_pkg::CNT_W'(1);
        else if (32'(node_count_reg) > sgr_pkg::MAX_NODES)
            cfg.eff_nodes = sgr_pkg::CNT_W'(sgr_pkg::MAX_NODES);
        else
            cfg.eff_nodes = sgr_pkg::CNT_W'(node_count_reg);
        if (edge_budget_reg == '0)
            cfg.eff_budget = sgr_pkg::FREE_W'(1);
        else if (32'(edge_budget_reg) > sgr_pkg::MAX_EDGES)
            cfg.eff_budget = sgr_pkg::FREE_W'(sgr_pkg::MAX_EDGES);
        else
            cfg.eff_budget = sgr_pkg::FREE_W'(edge_budget_reg);
    end

endmodule

/* src/switched_graph_reachability.sv */
// Top level: edge label memory, depth-first search sequencer and result register.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_mode s_node_a s_node_b s_edge_label
//  m_        out        m_valid/m_ready    m_status m_visited_node m_last
//  APB       in         psel/penable       paddr pwdata -> prdata, pready tied high
//
// One item at a time; the single-port edge memory (one read or one write a cycle,
// registered read data) sets the pace. Connect and disconnect read the entry, check it
// and write both halves; label removal reads each upper-triangle entry and clears both
// halves of a match; a search reads one entry per neighbor probe and pops to backtrack.
// Reset is synchronous; it empties the matrix at once through per-entry valid bits.
// A stalled m_ready holds the search until the result register frees up.
`timescale 1ns / 1ps
module switched_graph_reachability (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sgr_pkg::MODE_W-1:0]     s_mode,
    input  logic [sgr_pkg::NODE_W-1:0]     s_node_a,
    input  logic [sgr_pkg::NODE_W-1:0]     s_node_b,
    input  logic [sgr_pkg::LABEL_W-1:0]    s_edge_label,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sgr_pkg::STATUS_W-1:0]   m_status,
    output logic [sgr_pkg::NODE_W-1:0]     m_visited_node,
    output logic                           m_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sgr_pkg::PADDR_W-1:0]    paddr,
    input  logic [sgr_pkg::PDATA_W-1:0]    pwdata,
    output logic [sgr_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_C_CHK = 4'd1;
    localparam logic [3:0] S_C_W2  = 4'd2;
    localparam logic [3:0] S_D_RD  = 4'd3;
    localparam logic [3:0] S_D_CHK = 4'd4;
    localparam logic [3:0] S_D_LD  = 4'd5;
    localparam logic [3:0] S_L_RD  = 4'd6;
    localparam logic [3:0] S_L_CHK = 4'd7;
    localparam logic [3:0] S_L_W2  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam int IW = sgr_pkg::NODE_IW;
    localparam int CW = sgr_pkg::CNT_W;
    localparam int FW = sgr_pkg::FREE_W;
    localparam int AW = sgr_pkg::ADDR_W;
    localparam int LW = sgr_pkg::LABEL_W;
    localparam int NW = sgr_pkg::NODE_W;
    localparam int DEPTH = sgr_pkg::MAX_NODES * sgr_pkg::MAX_NODES;

    sgr_pkg::cfg_t cfg;

    sgr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // edge label memory
    logic [LW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] mem_vld_reg;
    logic [LW-1:0]    rd_data_reg;
    logic             mem_re, mem_we, mem_clr;
    logic [AW-1:0]    mem_ra, mem_wa;
    logic [LW-1:0]    mem_wd;

    // search stack
    logic [IW-1:0] stk_node [sgr_pkg::MAX_NODES];
    logic [CW-1:0] stk_next [sgr_pkg::MAX_NODES];
    logic [IW-1:0] stk_node_q;
    logic [CW-1:0] stk_next_q;
    logic          sn_we, sx_we;
    logic [IW-1:0] sn_wa, sx_wa, sn_wd, stk_ra;
    logic [CW-1:0] sx_wd;

    logic [3:0]                    state_reg, state_next;
    logic [sgr_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic [IW-1:0]                 a_reg, a_next, b_reg, b_next;
    logic [LW-1:0]                 label_reg, label_next;
    logic [IW-1:0]                 cur_reg, cur_next;
    logic [CW-1:0]                 j_reg, j_next;
    logic [CW-1:0]                 depth_reg, depth_next;
    logic [FW-1:0]                 free_reg, free_next;
    logic [sgr_pkg::MAX_NODES-1:0] visited_reg, visited_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [NW-1:0]                 pend_node_reg, pend_node_next;
    logic [sgr_pkg::STATUS_W-1:0]  status_reg, status_next;

    logic                          emit;
    logic [sgr_pkg::STATUS_W-1:0]  e_status;
    logic [NW-1:0]                 e_node;
    logic                          e_last;
    logic                          out_free;
    logic                          a_ok, b_ok;
    logic [IW-1:0]                 j_idx;
    logic [FW-1:0]                 free_inc;

    assign out_free = !m_valid || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign a_ok     = (s_node_a != '0) && (CW'(s_node_a) <= cfg.eff_nodes);
    assign b_ok     = (s_node_b != '0) && (CW'(s_node_b) <= cfg.eff_nodes);
    assign j_idx    = j_reg[IW-1:0];
    assign free_inc = (free_reg < cfg.eff_budget) ? FW'(free_reg + 1'b1) : free_reg;
    assign stk_ra   = IW'(depth_next - 1'b1);

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        label_next      = label_reg;
        cur_next        = cur_reg;
        j_next          = j_reg;
        depth_next      = depth_reg;
        free_next       = free_reg;
        visited_next    = visited_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        status_next     = status_reg;
        emit     = 1'b0;
        e_status = sgr_pkg::ST_DONE;
        e_node   = '0;
        e_last   = 1'b0;
        mem_re   = 1'b0;
        mem_ra   = '0;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_clr  = 1'b0;
        sn_we    = 1'b0;
        sn_wa    = '0;
        sn_wd    = '0;
        sx_we    = 1'b0;
        sx_wa    = '0;
        sx_wd    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    a_next      = IW'(s_node_a - 1'b1);
                    b_next      = IW'(s_node_b - 1'b1);
                    label_next  = s_edge_label;
                    status_next = sgr_pkg::ST_IGNORED;
                    state_next  = S_FIN;
                    case (s_mode) inside
                        sgr_pkg::MODE_CONNECT, sgr_pkg::MODE_DISCONNECT: begin
                            if (!a_ok || !b_ok) begin
                                status_next = sgr_pkg::ST_RANGE;
                            end else begin
                                mem_re     = 1'b1;
                                mem_ra     = {IW'(s_node_a - 1'b1), IW'(s_node_b - 1'b1)};
                                state_next = S_C_CHK;
                            end
                        end
                        sgr_pkg::MODE_DEL_LABEL: begin
                            if (s_edge_label != '0) begin
                                cur_next   = '0;
                                j_next     = '0;
                                state_next = S_L_RD;
                            end
                        end
                        sgr_pkg::MODE_CLEAR_ALL: begin
                            mem_clr     = 1'b1;
                            free_next   = cfg.eff_budget;
                            status_next = sgr_pkg::ST_DONE;
                        end
                        sgr_pkg::MODE_SEARCH: begin
                            if (!a_ok) begin
                                status_next = sgr_pkg::ST_RANGE;
                            end else begin
                                status_next = sgr_pkg::ST_NONE;
                                if (!visited_reg[IW'(s_node_a - 1'b1)]) begin
                                    visited_next[IW'(s_node_a - 1'b1)] = 1'b1;
                                    pend_valid_next = 1'b1;
                                    pend_node_next  = s_node_a;
                                end
                                sn_we      = 1'b1;
                                sn_wa      = '0;
                                sn_wd      = IW'(s_node_a - 1'b1);
                                cur_next   = IW'(s_node_a - 1'b1);
                                j_next     = '0;
                                depth_next = CW'(1);
                                state_next = S_D_RD;
                            end
                        end
                        sgr_pkg::MODE_CLEAR_VIS: begin
                            visited_next = '0;
                            status_next  = sgr_pkg::ST_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_C_CHK: begin
                state_next = S_FIN;
                if (mode_reg == sgr_pkg::MODE_CONNECT) begin
                    if (free_reg != '0 && label_reg != '0 && rd_data_reg == '0) begin
                        mem_we      = 1'b1;
                        mem_wa      = {a_reg, b_reg};
                        mem_wd      = label_reg;
                        free_next   = FW'(free_reg - 1'b1);
                        status_next = sgr_pkg::ST_DONE;
                        state_next  = S_C_W2;
                    end
                end else if (rd_data_reg != '0) begin
                    mem_we      = 1'b1;
                    mem_wa      = {a_reg, b_reg};
                    free_next   = free_inc;
                    status_next = sgr_pkg::ST_DONE;
                    state_next  = S_C_W2;
                end
            end
            S_C_W2: begin
                mem_we     = 1'b1;
                mem_wa     = {b_reg, a_reg};
                mem_wd     = (mode_reg == sgr_pkg::MODE_CONNECT) ? label_reg : '0;
                state_next = S_FIN;
            end
            S_D_RD: begin
                if (j_reg >= cfg.eff_nodes) begin
                    depth_next = CW'(depth_reg - 1'b1);
                    state_next = (depth_reg == CW'(1)) ? S_FIN : S_D_LD;
                end else begin
                    mem_re     = 1'b1;
                    mem_ra     = {cur_reg, j_idx};
                    state_next = S_D_CHK;
                end
            end
            S_D_LD: begin
                cur_next   = stk_node_q;
                j_next     = stk_next_q;
                state_next = S_D_RD;
            end
            S_D_CHK: begin
                if (rd_data_reg != '0 && !visited_reg[j_idx]) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            emit     = 1'b1;
                            e_status = sgr_pkg::ST_DONE;
                            e_node   = pend_node_reg;
                        end
                        pend_valid_next     = 1'b1;
                        pend_node_next      = NW'(j_reg + 1'b1);
                        visited_next[j_idx] = 1'b1;
                        sx_we = 1'b1;
                        sx_wa = IW'(depth_reg - 1'b1);
                        sx_wd = CW'(j_reg + 1'b1);
                        if (32'(depth_reg) < sgr_pkg::MAX_NODES) begin
                            sn_we      = 1'b1;
                            sn_wa      = depth_reg[IW-1:0];
                            sn_wd      = j_idx;
                            depth_next = CW'(depth_reg + 1'b1);
                            cur_next   = j_idx;
                            j_next     = '0;
                        end else begin
                            j_next = CW'(j_reg + 1'b1);
                        end
                        state_next = S_D_RD;
                    end
                end else begin
                    j_next     = CW'(j_reg + 1'b1);
                    state_next = S_D_RD;
                end
            end
            S_L_RD: begin
                if (j_reg >= cfg.eff_nodes) begin
                    if (CW'(cur_reg) + 1'b1 >= cfg.eff_nodes) begin
                        state_next = S_FIN;
                    end else begin
                        cur_next = IW'(cur_reg + 1'b1);
                        j_next   = CW'(cur_reg) + 1'b1;
                    end
                end else begin
                    mem_re     = 1'b1;
                    mem_ra     = {cur_reg, j_idx};
                    state_next = S_L_CHK;
                end
            end
            S_L_CHK: begin
                if (rd_data_reg == label_reg) begin
                    mem_we      = 1'b1;
                    mem_wa      = {cur_reg, j_idx};
                    free_next   = free_inc;
                    status_next = sgr_pkg::ST_DONE;
                    state_next  = S_L_W2;
                end else begin
                    j_next     = CW'(j_reg + 1'b1);
                    state_next = S_L_RD;
                end
            end
            S_L_W2: begin
                mem_we     = 1'b1;
                mem_wa     = {j_idx, cur_reg};
                j_next     = CW'(j_reg + 1'b1);
                state_next = S_L_RD;
            end
            S_FIN: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (pend_valid_reg) begin
                        e_status = sgr_pkg::ST_DONE;
                        e_node   = pend_node_reg;
                    end else begin
                        e_status = status_reg;
                    end
                    pend_valid_next = 1'b0;
                    depth_next      = '0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            depth_reg      <= '0;
            free_reg       <= FW'(sgr_pkg::MAX_EDGES);
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            free_reg       <= free_next;
            visited_reg    <= visited_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
                m_valid <= 1'b1;
            else if (m_ready)
                m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        label_reg     <= label_next;
        cur_reg       <= cur_next;
        j_reg         <= j_next;
        pend_node_reg <= pend_node_next;
        status_reg    <= status_next;
        if (emit) begin
            m_status       <= e_status;
            m_visited_node <= e_node;
            m_last         <= e_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || mem_clr)
            mem_vld_reg <= '0;
        else if (mem_we)
            mem_vld_reg[mem_wa] <= 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem_vld_reg[mem_ra] ? mem[mem_ra] : '0;
    end

    always_ff @(posedge aclk) begin
        if (sn_we)
            stk_node[sn_wa] <= sn_wd;
        if (sx_we)
            stk_next[sx_wa] <= sx_wd;
        stk_node_q <= stk_node[stk_ra];
        stk_next_q <= stk_next[stk_ra];
    end

`ifndef SYNTH
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending search result left over in idle");
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(free_reg) <= sgr_pkg::MAX_EDGES)
        else $error("free edge count above maximum");
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= sgr_pkg::MAX_NODES)
        else $error("search stack overflow");
    a_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !mem_re)
        else $error("edge memory read and write in one cycle");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result beat overwritten");
`endif

endmodule

/* verif/switched_graph_reachability_checker.sv */
// Checker: watches both channels and the register port, predicts results and compares them.
`timescale 1ns / 1ps
module switched_graph_reachability_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [sgr_pkg::MODE_W-1:0]   s_mode,
    input  logic [sgr_pkg::NODE_W-1:0]   s_node_a,
    input  logic [sgr_pkg::NODE_W-1:0]   s_node_b,
    input  logic [sgr_pkg::LABEL_W-1:0]  s_edge_label,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [sgr_pkg::STATUS_W-1:0] m_status,
    input  logic [sgr_pkg::NODE_W-1:0]   m_visited_node,
    input  logic                         m_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [sgr_pkg::PADDR_W-1:0]  paddr,
    input  logic [sgr_pkg::PDATA_W-1:0]  pwdata,
    output int                           fail_count,
    output int                           pending_count
);

    typedef struct packed {
        logic [sgr_pkg::STATUS_W-1:0] status;
        logic [sgr_pkg::NODE_W-1:0]   node;
        logic                         last;
    } beat_t;

    beat_t       expected_beats[$];
    logic [5:0]  labels[sgr_pkg::MAX_NODES][sgr_pkg::MAX_NODES];
    logic        seen[sgr_pkg::MAX_NODES];
    int          free_cnt;
    logic [4:0]  ncount_reg;
    logic [5:0]  budget_reg;

    assign pending_count = expected_beats.size();

    function automatic int eff_n();
        if (ncount_reg < 1) return 1;
        if (ncount_reg > sgr_pkg::MAX_NODES) return sgr_pkg::MAX_NODES;
        return int'(ncount_reg);
    endfunction

    function automatic int eff_b();
        if (budget_reg < 1) return 1;
        if (budget_reg > sgr_pkg::MAX_EDGES) return sgr_pkg::MAX_EDGES;
        return int'(budget_reg);
    endfunction

    function automatic void push_beat(logic [sgr_pkg::STATUS_W-1:0] st, int node, logic lst);
        beat_t b;
        b.status = st;
        b.node   = node[sgr_pkg::NODE_W-1:0];
        b.last   = lst;
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    function automatic void walk_graph(int start, int n);
        int stk_node[sgr_pkg::MAX_NODES];
        int stk_next[sgr_pkg::MAX_NODES];
        int depth;
        int cnt;
        int cur;
        int j;
        cnt = 0;
        if (!seen[start]) begin
            seen[start] = 1'b1;
            push_beat(sgr_pkg::ST_DONE, start + 1, 1'b0);
            cnt++;
        end
        stk_node[0] = start;
        stk_next[0] = 0;
        depth = 1;
        while (depth > 0) begin
            cur = stk_node[depth-1];
            j = stk_next[depth-1];
            while (j < n && (labels[cur][j] == 0 || seen[j])) j++;
            if (j >= n) begin
                depth--;
            end else begin
                stk_next[depth-1] = j + 1;
                seen[j] = 1'b1;
                push_beat(sgr_pkg::ST_DONE, j + 1, 1'b0);
                cnt++;
                if (depth < sgr_pkg::MAX_NODES) begin
                    stk_node[depth] = j;
                    stk_next[depth] = 0;
                    depth++;
                end
            end
        end
        if (cnt == 0) push_beat(sgr_pkg::ST_NONE, 0, 1'b1);
        else expected_beats[expected_beats.size()-1].last = 1'b1;
    endfunction

    function automatic void predict_op(logic [sgr_pkg::MODE_W-1:0] mode, int a, int b, int lbl);
        int n;
        logic [sgr_pkg::STATUS_W-1:0] st;
        n = eff_n();
        st = sgr_pkg::ST_IGNORED;
        case (mode)
            sgr_pkg::MODE_CONNECT: begin
                if (a < 1 || a > n || b < 1 || b > n) st = sgr_pkg::ST_RANGE;
                else if (free_cnt != 0 && lbl != 0 && labels[a-1][b-1] == 0) begin
                    labels[a-1][b-1] = lbl[5:0];
                    labels[b-1][a-1] = lbl[5:0];
                    free_cnt--;
                    st = sgr_pkg::ST_DONE;
                end
            end
            sgr_pkg::MODE_DISCONNECT: begin
                if (a < 1 || a > n || b < 1 || b > n) st = sgr_pkg::ST_RANGE;
                else if (labels[a-1][b-1] != 0) begin
                    labels[a-1][b-1] = '0;
                    labels[b-1][a-1] = '0;
                    if (free_cnt < eff_b()) free_cnt++;
                    st = sgr_pkg::ST_DONE;
                end
            end
            sgr_pkg::MODE_DEL_LABEL: begin
                if (lbl != 0) begin
                    for (int i = 0; i < n; i++) begin
                        for (int k = 0; k < n; k++) begin
                            if (labels[i][k] == lbl) begin
                                labels[i][k] = '0;
                                labels[k][i] = '0;
                                if (free_cnt < eff_b()) free_cnt++;
                                st = sgr_pkg::ST_DONE;
                            end
                        end
                    end
                end
            end
            sgr_pkg::MODE_CLEAR_ALL: begin
                for (int i = 0; i < sgr_pkg::MAX_NODES; i++)
                    for (int k = 0; k < sgr_pkg::MAX_NODES; k++) labels[i][k] = '0;
                free_cnt = eff_b();
                st = sgr_pkg::ST_DONE;
            end
            sgr_pkg::MODE_SEARCH: begin
                if (a < 1 || a > n) st = sgr_pkg::ST_RANGE;
                else begin
                    walk_graph(a - 1, n);
                    return;
                end
            end
            sgr_pkg::MODE_CLEAR_VIS: begin
                for (int i = 0; i < sgr_pkg::MAX_NODES; i++) seen[i] = 1'b0;
                st = sgr_pkg::ST_DONE;
            end
            default: st = sgr_pkg::ST_IGNORED;
        endcase
        push_beat(st, 0, 1'b1);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        ncount_reg = 5'd16;
        budget_reg = 6'd32;
        free_cnt = sgr_pkg::MAX_EDGES;
        for (int i = 0; i < sgr_pkg::MAX_NODES; i++) begin
            seen[i] = 1'b0;
            for (int k = 0; k < sgr_pkg::MAX_NODES; k++) labels[i][k] = '0;
        end
    end

    always @(posedge aclk) begin
        beat_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", m_status, 0);
                end else begin
                    w = expected_beats.pop_front();
                    if (m_status !== w.status) report_mismatch("status", m_status, w.status);
                    if (m_visited_node !== w.node)
                        report_mismatch("visited_node", m_visited_node, w.node);
                    if (m_last !== w.last) report_mismatch("last", m_last, w.last);
                end
            end
            if (s_valid && s_ready)
                predict_op(s_mode, s_node_a, s_node_b, s_edge_label);
            if (psel && penable && pwrite && pready) begin
                if (paddr[sgr_pkg::PADDR_W-1:2] == sgr_pkg::REG_NODE_COUNT)
                    ncount_reg = pwdata[4:0];
                else if (paddr[sgr_pkg::PADDR_W-1:2] == sgr_pkg::REG_EDGE_BUDGET)
                    budget_reg = pwdata[5:0];
            end
        end
    end

endmodule

/* verif/switched_graph_reachability_tb.sv */
// Testbench top: clock, reset, stimulus, register writes and the final verdict.
`timescale 1ns / 1ps
module switched_graph_reachability_tb;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [sgr_pkg::MODE_W-1:0]   s_mode = '0;
    logic [sgr_pkg::NODE_W-1:0]   s_node_a = '0;
    logic [sgr_pkg::NODE_W-1:0]   s_node_b = '0;
    logic [sgr_pkg::LABEL_W-1:0]  s_edge_label = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [sgr_pkg::STATUS_W-1:0] m_status;
    logic [sgr_pkg::NODE_W-1:0]   m_visited_node;
    logic                         m_last;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [sgr_pkg::PADDR_W-1:0]  paddr = '0;
    logic [sgr_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [sgr_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;
    int                           fail_count;
    int                           pending_count;
    int                           cycle_count = 0;
    bit                           calm = 1'b0;
    int                           sink_hold = 0;
    int                           cur_n = 16;

    localparam int CYCLE_LIMIT = 1500000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    switched_graph_reachability u_top (.*);

    switched_graph_reachability_checker u_chk (.*);

    // random backpressure on the result side
    always @(posedge aclk) begin
        if (calm || !aresetn) begin
            m_ready <= aresetn;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("[switched_graph_reachability] ERROR");
            $finish;
        end
    end

    task automatic send_beat(logic [sgr_pkg::MODE_W-1:0] mode, int a, int b, int lbl);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_node_a <= a[sgr_pkg::NODE_W-1:0];
        s_node_b <= b[sgr_pkg::NODE_W-1:0];
        s_edge_label <= lbl[sgr_pkg::LABEL_W-1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0 || !s_ready) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [sgr_pkg::PADDR_W-3:0] idx, int val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_beat(sgr_pkg::MODE_CONNECT, $urandom_range(1, cur_n),
                          $urandom_range(1, cur_n), $urandom_range(1, 8));
            else if (r < 55)
                send_beat(sgr_pkg::MODE_DISCONNECT, $urandom_range(1, cur_n),
                          $urandom_range(1, cur_n), 0);
            else if (r < 62)
                send_beat(sgr_pkg::MODE_DEL_LABEL, 0, 0, $urandom_range(0, 9));
            else if (r < 64) send_beat(sgr_pkg::MODE_CLEAR_ALL, 0, 0, 0);
            else if (r < 80) send_beat(sgr_pkg::MODE_SEARCH, $urandom_range(1, cur_n), 0, 0);
            else if (r < 88) send_beat(sgr_pkg::MODE_CLEAR_VIS, 0, 0, 0);
            else
                send_beat(3'($urandom_range(0, 7)), $urandom_range(0, 31),
                          $urandom_range(0, 31), $urandom_range(0, 63));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed
        send_beat(sgr_pkg::MODE_CONNECT, 1, 16, 63);
        send_beat(sgr_pkg::MODE_CONNECT, 16, 1, 5);
        send_beat(sgr_pkg::MODE_CONNECT, 3, 3, 7);
        send_beat(sgr_pkg::MODE_CONNECT, 2, 3, 0);
        send_beat(sgr_pkg::MODE_CONNECT, 0, 3, 4);
        send_beat(sgr_pkg::MODE_CONNECT, 17, 31, 4);
        send_beat(sgr_pkg::MODE_CONNECT, 16, 2, 32);
        send_beat(sgr_pkg::MODE_SEARCH, 1, 0, 0);
        send_beat(sgr_pkg::MODE_SEARCH, 1, 0, 0);
        send_beat(sgr_pkg::MODE_SEARCH, 3, 0, 0);
        send_beat(sgr_pkg::MODE_SEARCH, 0, 0, 0);
        send_beat(sgr_pkg::MODE_DISCONNECT, 4, 5, 0);
        send_beat(sgr_pkg::MODE_DISCONNECT, 16, 1, 0);
        send_beat(sgr_pkg::MODE_DEL_LABEL, 0, 0, 32);
        send_beat(sgr_pkg::MODE_DEL_LABEL, 0, 0, 0);
        send_beat(sgr_pkg::MODE_DEL_LABEL, 0, 0, 9);
        send_beat(sgr_pkg::MODE_CLEAR_VIS, 0, 0, 0);
        send_beat(sgr_pkg::MODE_SEARCH, 3, 0, 0);
        send_beat(sgr_pkg::MODE_CLEAR_ALL, 0, 0, 0);
        send_beat(3'd6, 1, 1, 1);
        send_beat(3'd7, 31, 31, 63);
        drain();
        write_reg(sgr_pkg::REG_NODE_COUNT, 4);
        write_reg(sgr_pkg::REG_EDGE_BUDGET, 1);
        cur_n = 4;
        send_beat(sgr_pkg::MODE_CONNECT, 1, 2, 3);
        send_beat(sgr_pkg::MODE_CONNECT, 2, 3, 3);
        send_beat(sgr_pkg::MODE_SEARCH, 5, 0, 0);
        random_phase(70);
        drain();
        write_reg(sgr_pkg::REG_NODE_COUNT, 0);
        write_reg(sgr_pkg::REG_EDGE_BUDGET, 0);
        cur_n = 2;
        random_phase(20);
        drain();
        write_reg(sgr_pkg::REG_NODE_COUNT, 31);
        write_reg(sgr_pkg::REG_EDGE_BUDGET, 63);
        cur_n = 16;
        random_phase(120);
        drain();
        write_reg(sgr_pkg::REG_NODE_COUNT, 8);
        write_reg(sgr_pkg::REG_EDGE_BUDGET, 12);
        cur_n = 8;
        random_phase(90);
        drain();
        write_reg(sgr_pkg::REG_NODE_COUNT, 16);
        write_reg(sgr_pkg::REG_EDGE_BUDGET, 32);
        cur_n = 16;
        calm = 1'b1;
        random_phase(60);
        drain();
        if (fail_count == 0) begin
            $display("[switched_graph_reachability] OK");
        end else begin
            $display("[switched_graph_reachability] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
src/sgr_pkg.sv
src/sgr_cfg.sv
src/switched_graph_reachability.sv
verif/switched_graph_reachability_checker.sv
verif/switched_graph_reachability_tb.sv
